[hw/rtl/md3vn_pkg.sv]
// Package for the vertex and normal decoder: item types, trig tables and their builder.
`timescale 1ns / 1ps

package md3vn_pkg;

  // Fraction bits of the normal components by default.
  localparam int unsigned NormalFracBits = 14;

  // Width of a table entry: holds +/-2^16 for the widest normal format.
  localparam int unsigned TabW = 18;
  localparam int unsigned TabDepth = 256;

  // Fixed point with 60 fraction bits for building the tables.
  localparam int unsigned QBits = 60;
  localparam logic [63:0] OneQ60 = 64'd1 << QBits;
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] TwoPiQ60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] StepQ60 = TwoPiQ60 / 64'd255;

  typedef logic signed [TabW-1:0] tab_t [TabDepth];

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [7:0]         normal_lo_byte;
    logic [7:0]         normal_hi_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } out_item_t;

  // Q60 product, truncated, wrapping at 64 bits.
  function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series of sine and cosine; returns {sin, cos} in Q60.
  function automatic logic [127:0] series(logic [63:0] y);
    logic [63:0] ts;
    logic [63:0] tc;
    logic [63:0] acc_s;
    logic [63:0] acc_c;
    ts = y;
    tc = OneQ60;
    acc_s = y;
    acc_c = OneQ60;
    for (int n = 1; n <= 20; n++) begin
      ts = mulq(ts, y) / 64'(2 * n);
      ts = mulq(ts, y) / 64'(2 * n + 1);
      tc = mulq(tc, y) / 64'(2 * n - 1);
      tc = mulq(tc, y) / 64'(2 * n);
      if ((n % 2) == 1) begin
        acc_s = acc_s - ts;
        acc_c = acc_c - tc;
      end else begin
        acc_s = acc_s + ts;
        acc_c = acc_c + tc;
      end
    end
    return {acc_s, acc_c};
  endfunction

  // Rounds a Q60 magnitude to the given number of fraction bits, ties away from zero.
  function automatic logic [63:0] round_q(logic [63:0] v, int unsigned frac);
    return (v + (64'd1 << (QBits - frac - 1))) >> (QBits - frac);
  endfunction

  // Builds the sine table, or the cosine table when want_cos is set.
  function automatic tab_t build_tab(int unsigned frac, logic want_cos);
    tab_t        t;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] m;
    logic [127:0] sc;
    logic        second;
    logic [TabW-1:0] v;
    for (int k = 0; k < TabDepth / 2; k++) begin
      x = StepQ60 * 64'(k);
      second = (k > 63);
      y = second ? (PiQ60 - x) : x;
      sc = series(y);
      if (want_cos) begin
        m = round_q(sc[63:0], frac);
        v = second ? (-m[TabW-1:0]) : m[TabW-1:0];
        t[k] = v;
        t[TabDepth-1-k] = v;
      end else begin
        m = round_q(sc[127:64], frac);
        t[k] = m[TabW-1:0];
        t[TabDepth-1-k] = -m[TabW-1:0];
      end
    end
    return t;
  endfunction

endpackage

[hw/rtl/md3_vertex_normal_decode.sv]
// Top level of the vertex decoder: passes coordinates and turns normal bytes into a unit normal.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake              | Payload
//  in      | input     | in_valid_i/in_ready_o  | in_item_i  (md3vn_pkg::in_item_t)
//  out     | output    | out_valid_o/out_ready_i| out_item_o (md3vn_pkg::out_item_t)
//
// One item may be accepted every cycle while the output is not stalled; its result passes
// through the input register and then the result register, with the table lookups and one
// multiply each for the x and y normal axes between them.
// Reset clears the valid bits of both registers only.
// A stall on the output holds the result and backs up through the input register.

module md3_vertex_normal_decode #(
  parameter int unsigned NORMAL_FRAC_BITS = md3vn_pkg::NormalFracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  md3vn_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output md3vn_pkg::out_item_t out_item_o
);

  localparam int unsigned TabW = md3vn_pkg::TabW;
  localparam int unsigned ProdW = 2 * TabW + 1;
  localparam md3vn_pkg::tab_t SinTab = md3vn_pkg::build_tab(NORMAL_FRAC_BITS, 1'b0);
  localparam md3vn_pkg::tab_t CosTab = md3vn_pkg::build_tab(NORMAL_FRAC_BITS, 1'b1);
  localparam logic signed [ProdW-1:0] HalfLsb = ProdW'(1) <<< (NORMAL_FRAC_BITS - 1);
  localparam logic signed [TabW-1:0] OneQ = TabW'(1) <<< NORMAL_FRAC_BITS;

  function automatic logic signed [15:0] sat16(logic signed [ProdW-1:0] v);
    if (v > ProdW'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -ProdW'(32768)) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic                 s1_valid_q, s1_valid_d;
  md3vn_pkg::in_item_t  s1_item_q;
  logic                 out_valid_q, out_valid_d;
  md3vn_pkg::out_item_t out_item_q, out_item_d;
  logic                 out_load;
  logic                 in_load;

  logic signed [TabW-1:0]    sin_lat, cos_lat, sin_lng, cos_lng;
  logic signed [ProdW-1:0]   prod_x, prod_y;

  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_load || (s1_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_comb begin
    sin_lat = SinTab[s1_item_q.normal_hi_byte];
    cos_lat = CosTab[s1_item_q.normal_hi_byte];
    sin_lng = SinTab[s1_item_q.normal_lo_byte];
    cos_lng = CosTab[s1_item_q.normal_lo_byte];
    prod_x = ProdW'(cos_lat) * ProdW'(sin_lng);
    prod_y = ProdW'(sin_lat) * ProdW'(sin_lng);
    out_item_d.pos_x  = s1_item_q.coord_x;
    out_item_d.pos_y  = s1_item_q.coord_y;
    out_item_d.pos_z  = s1_item_q.coord_z;
    out_item_d.norm_x = sat16((prod_x + HalfLsb) >>> NORMAL_FRAC_BITS);
    out_item_d.norm_y = sat16((prod_y + HalfLsb) >>> NORMAL_FRAC_BITS);
    out_item_d.norm_z = sat16(ProdW'(cos_lng));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_item_q <= in_item_i;
    end
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // An item moving into the result register carries its x and z coordinates unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_item_o.pos_x == $past(s1_item_q.coord_x)) &&
                 (out_item_o.pos_z == $past(s1_item_q.coord_z)))
    else $error("coordinates altered on the way to the result register");

  // The input side only stalls while the input register holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // The x and z normal components stay within one unit when the format leaves headroom.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (NORMAL_FRAC_BITS <= 14)) |->
      (16'(OneQ) >= out_item_o.norm_z) && (out_item_o.norm_z >= -16'(OneQ)) &&
      (16'(OneQ) >= out_item_o.norm_x) && (out_item_o.norm_x >= -16'(OneQ)))
    else $error("normal component beyond unit length");
`endif

endmodule
